// ===== hw/rtl/ffha_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_pkg: shared types and constants of the first-fit heap allocator
// Heap geometry, header layout, word packing and the op / status codes.
// ----------------------------------------------------------------------------
package ffha_pkg;

  localparam int HEAP_WORDS = 4096;                 // 8-byte heap words
  localparam int ADDR_W     = $clog2(HEAP_WORDS);   // header store index
  localparam int SIZE_W     = ADDR_W + 1;           // block size in words, 0..HEAP_WORDS
  localparam int HDR_W      = SIZE_W + 1;           // {size, used}

  localparam int REQ_W      = 16;                   // request_bytes
  localparam int OFF_W      = 15;                   // byte offsets
  localparam int NEED_W     = REQ_W - 2;            // ceil((bytes + 8) / 8)
  localparam int CMP_W      = (NEED_W > SIZE_W) ? NEED_W : SIZE_W;

  localparam int S_DATA_W   = ((REQ_W + OFF_W + 7) / 8) * 8;
  localparam int M_DATA_W   = ((OFF_W + 7) / 8) * 8;

  // Header value of entry 0 right after reset: whole heap, free.
  localparam logic [HDR_W-1:0] HDR_RST = {SIZE_W'(HEAP_WORDS), 1'b0};

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    STAT_DONE    = 2'd0,
    STAT_ZERO    = 2'd1,
    STAT_NOFIT   = 2'd2,
    STAT_IGNORED = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_SPLIT,
    ST_FREE,
    ST_FINISH
  } state_e;

endpackage

// ===== hw/rtl/first_fit_heap_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_heap_allocator: first-fit allocator over an implicit free list
// One header store (single write port, one registered read port) is walked
// by a small sequencer, one header per cycle.
// ----------------------------------------------------------------------------
// Flow: an alloc walks the headers from word 0, one per cycle through the registered
//   store read, and passes ST_SPLIT when a block is split. An aligned in-heap free
//   passes ST_FREE; a zero-size request or a null / misaligned free goes to ST_FINISH.
// Throughput: one word in flight, and ST_FINISH holds while the output register is full;
//   the next word is taken the cycle after the result enters the output register.
// Reset: rst_ni async, active low; entry 0 reads as the whole heap, free, until written.
module first_fit_heap_allocator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input words
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [ffha_pkg::S_DATA_W-1:0] s_axis_tdata_i,  // [15:0] request_bytes,
                                                         // [30:16] release_offset, [31] 0
  input  logic                          s_axis_tuser_i,  // [0] op
  // result words
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [ffha_pkg::M_DATA_W-1:0] m_axis_tdata_o,  // [14:0] payload_offset, [15] 0
  output logic [1:0]                    m_axis_tuser_o   // [1:0] status
);
  import ffha_pkg::*;

  // --------------------------------------------------------------------------
  // Header store: {size, used} per heap word. Only headers reached from word 0
  // are ever read by the walk; all of those but an unwritten entry 0 have been written.
  // --------------------------------------------------------------------------
  logic [HDR_W-1:0]  mem [HEAP_WORDS];
  logic [HDR_W-1:0]  rdata_q;
  logic              rd_rst_q;     // last read hit entry 0 before its first write
  logic              hdr0_vld_q;   // entry 0 has been written since reset

  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [HDR_W-1:0]  wr_data;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr0_vld_q <= 1'b0;
      rd_rst_q   <= 1'b0;
    end else begin
      if (wr_en && (wr_addr == '0)) begin
        hdr0_vld_q <= 1'b1;
      end
      rd_rst_q <= (rd_addr == '0) && !hdr0_vld_q;
    end
  end

  // Header as seen by the sequencer
  logic [HDR_W-1:0]  hdr;
  logic [SIZE_W-1:0] blk_size;
  logic              hdr_used;

  assign hdr      = rd_rst_q ? HDR_RST : rdata_q;
  assign blk_size = hdr[HDR_W-1:1];
  assign hdr_used = hdr[0];

  // --------------------------------------------------------------------------
  // Sequencer state
  // --------------------------------------------------------------------------
  state_e              state_q, state_d;
  logic [SIZE_W-1:0]   w_q, w_d;        // current header word (free: target word)
  logic [NEED_W-1:0]   need_q, need_d;  // block size requested, in words
  logic [CMP_W-1:0]    rem_q, rem_d;    // split remainder in words
  status_e             res_stat_q, res_stat_d;
  logic [OFF_W-1:0]    res_off_q, res_off_d;

  // output register
  logic                out_vld_q, out_vld_d;
  status_e             out_stat_q, out_stat_d;
  logic [OFF_W-1:0]    out_off_q, out_off_d;

  // input word fields
  op_e                 in_op;
  logic [REQ_W-1:0]    in_bytes;
  logic [OFF_W-1:0]    in_off;
  logic [REQ_W:0]      bytes_plus;      // request + header + 7, before >> 3
  logic [OFF_W-4:0]    free_idx;

  assign in_op      = op_e'(s_axis_tuser_i);
  assign in_bytes   = s_axis_tdata_i[REQ_W-1:0];
  assign in_off     = s_axis_tdata_i[REQ_W+OFF_W-1:REQ_W];
  assign bytes_plus = {1'b0, in_bytes} + (REQ_W+1)'(15);
  assign free_idx   = in_off[OFF_W-1:3] - (OFF_W-3)'(1);

  // shared datapath pieces
  logic [SIZE_W-1:0]   limit;           // words left from w_q to heap end
  logic [SIZE_W-1:0]   next_w;          // adder: w_q + operand
  logic [SIZE_W-1:0]   add_b;
  logic [CMP_W-1:0]    remainder;

  assign limit     = SIZE_W'(HEAP_WORDS) - w_q;
  assign next_w    = w_q + add_b;
  assign remainder = CMP_W'(blk_size) - CMP_W'(need_q);

  assign s_axis_tready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d    = state_q;
    w_d        = w_q;
    need_d     = need_q;
    rem_d      = rem_q;
    res_stat_d = res_stat_q;
    res_off_d  = res_off_q;
    out_vld_d  = out_vld_q;
    out_stat_d = out_stat_q;
    out_off_d  = out_off_q;
    rd_addr    = '0;
    wr_en      = 1'b0;
    wr_addr    = '0;
    wr_data    = '0;
    add_b      = blk_size;

    if (out_vld_q && m_axis_tready_i) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          res_off_d = '0;
          w_d       = '0;
          unique case (in_op)
            OP_ALLOC: begin
              need_d = bytes_plus[REQ_W:3];
              if (in_bytes == '0) begin
                res_stat_d = STAT_ZERO;
                state_d    = ST_FINISH;
              end else begin
                rd_addr = '0;
                state_d = ST_WALK;
              end
            end
            OP_FREE: begin
              // null, misaligned or out of heap: ignored
              if ((in_off < OFF_W'(8)) || (in_off[2:0] != 3'd0) ||
                  (32'(free_idx) >= HEAP_WORDS)) begin
                res_stat_d = STAT_IGNORED;
                state_d    = ST_FINISH;
              end else begin
                rd_addr = ADDR_W'(free_idx);
                w_d     = SIZE_W'(free_idx);
                state_d = ST_FREE;
              end
            end
            default: ;
          endcase
        end
      end

      ST_WALK: begin
        add_b = blk_size;
        if ((blk_size == '0) || (blk_size > limit)) begin
          // broken chain or size past heap end
          res_stat_d = STAT_NOFIT;
          state_d    = ST_FINISH;
        end else if (!hdr_used && (CMP_W'(need_q) <= CMP_W'(blk_size))) begin
          wr_en      = 1'b1;
          wr_addr    = ADDR_W'(w_q);
          res_stat_d = STAT_DONE;
          res_off_d  = OFF_W'({w_q + SIZE_W'(1), 3'b000});
          if (remainder >= CMP_W'(2)) begin
            wr_data = {SIZE_W'(need_q), 1'b1};
            rem_d   = remainder;
            state_d = ST_SPLIT;
          end else begin
            wr_data = {blk_size, 1'b1};
            state_d = ST_FINISH;
          end
        end else if (32'(next_w) >= HEAP_WORDS) begin
          res_stat_d = STAT_NOFIT;
          state_d    = ST_FINISH;
        end else begin
          // fetch the next header, visited next cycle
          rd_addr = ADDR_W'(next_w);
          w_d     = next_w;
        end
      end

      ST_SPLIT: begin
        // tail header of the split block goes right after the taken part
        add_b   = SIZE_W'(need_q);
        wr_en   = 1'b1;
        wr_addr = ADDR_W'(next_w);
        wr_data = {SIZE_W'(rem_q), 1'b0};
        state_d = ST_FINISH;
      end

      ST_FREE: begin
        if (hdr_used) begin
          wr_en      = 1'b1;
          wr_addr    = ADDR_W'(w_q);
          wr_data    = {blk_size, 1'b0};
          res_stat_d = STAT_DONE;
        end else begin
          res_stat_d = STAT_IGNORED;
        end
        state_d = ST_FINISH;
      end

      ST_FINISH: begin
        // hand the result to the output register once it is free
        if (!out_vld_q || m_axis_tready_i) begin
          out_vld_d  = 1'b1;
          out_stat_d = res_stat_q;
          out_off_d  = res_off_q;
          state_d    = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q        <= w_d;
    need_q     <= need_d;
    rem_q      <= rem_d;
    res_stat_q <= res_stat_d;
    res_off_q  <= res_off_d;
    out_stat_q <= out_stat_d;
    out_off_q  <= out_off_d;
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = M_DATA_W'(out_off_q);
  assign m_axis_tuser_o  = out_stat_q;

endmodule

// ===== hw/rtl/ffha_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_checker: port-level checks of the first-fit heap allocator
// Watches the stream ports only; bound to the top level below.
// ----------------------------------------------------------------------------
module ffha_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  input  logic                          s_axis_tready_o,
  input  logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  input  logic [ffha_pkg::M_DATA_W-1:0] m_axis_tdata_o,
  input  logic [1:0]                    m_axis_tuser_o
);
  import ffha_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result word changed while stalled");

  // one word in flight: busy right after an accept
  a_one_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input accepted twice in a row");

  // a nonzero payload offset only comes with a successful allocation
  a_off_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tdata_o != '0) |-> m_axis_tuser_o == STAT_DONE)
    else $error("offset reported with failing status");

  // payload offsets are word aligned and never point at word 0
  a_off_align: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tdata_o != '0) |->
      (m_axis_tdata_o[2:0] == 3'd0) && (m_axis_tdata_o[OFF_W-1:3] != '0))
    else $error("misaligned payload offset");

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

// ===== tb/heap_alloc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heap_alloc_checker: result scoreboard for the first-fit heap allocator
// Keeps a shadow copy of the header store, predicts the status and payload
// offset of every accepted input word and compares them with the result words.
// ----------------------------------------------------------------------------
module heap_alloc_checker
  import ffha_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  input  logic                s_axis_tready_i,
  input  logic [S_DATA_W-1:0] s_axis_tdata_i,   // [15:0] request_bytes, [30:16] release_offset
  input  logic                s_axis_tuser_i,   // [0] op
  input  logic                m_axis_tvalid_i,
  input  logic                m_axis_tready_i,
  input  logic [M_DATA_W-1:0] m_axis_tdata_i,   // [14:0] payload_offset
  input  logic [1:0]          m_axis_tuser_i,   // [1:0] status
  output int                  mismatches_o,
  output int                  pending_o
);

  typedef struct packed {
    status_e          status;
    logic [OFF_W-1:0] offset;
  } heap_result_t;

  logic [HDR_W-1:0] shadow_hdr [HEAP_WORDS];
  heap_result_t     predicted_results [$];
  int               fail_count;

  // Header layout: {size in words, used}
  function automatic heap_result_t predict_heap_op(op_e op, logic [REQ_W-1:0] bytes,
                                                   logic [OFF_W-1:0] off);
    heap_result_t res;
    int unsigned  need;
    int unsigned  w;
    int unsigned  sz;
    int unsigned  idx;
    res.offset = '0;
    if (op == OP_ALLOC) begin
      res.status = STAT_NOFIT;
      if (bytes == '0) begin
        res.status = STAT_ZERO;
      end else begin
        need = (32'(bytes) + 15) >> 3;   // payload plus header, rounded up to words
        w = 0;
        while (w < HEAP_WORDS) begin
          sz = 32'(shadow_hdr[w][HDR_W-1:1]);
          if (sz == 0 || sz > HEAP_WORDS - w) break;
          if (!shadow_hdr[w][0] && need <= sz) begin
            if (sz - need >= 2) begin
              shadow_hdr[w]        = {SIZE_W'(need), 1'b1};
              shadow_hdr[w + need] = {SIZE_W'(sz - need), 1'b0};
            end else begin
              shadow_hdr[w][0] = 1'b1;   // remainder too small to split off
            end
            res.status = STAT_DONE;
            res.offset = OFF_W'((w + 1) << 3);
            break;
          end
          w += sz;
        end
      end
    end else begin
      res.status = STAT_IGNORED;
      if (off >= 8 && off[2:0] == 3'b000) begin
        idx = (32'(off) >> 3) - 1;
        if (idx < HEAP_WORDS && shadow_hdr[idx][0]) begin
          shadow_hdr[idx][0] = 1'b0;
          res.status = STAT_DONE;
        end
      end
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    heap_result_t want;
    if (!rst_ni) begin
      predicted_results.delete();
      for (int i = 0; i < HEAP_WORDS; i++) shadow_hdr[i] = '0;
      shadow_hdr[0] = HDR_RST;
      fail_count = 0;
    end else begin
      // drain before fill, so a stray result never meets its own request
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (predicted_results.size() == 0) begin
          $error("result word with nothing pending: status %0d offset %0d",
                 m_axis_tuser_i, m_axis_tdata_i[OFF_W-1:0]);
          fail_count++;
        end else begin
          want = predicted_results.pop_front();
          if (m_axis_tuser_i != want.status) begin
            $error("status: expected %0d, got %0d", want.status, m_axis_tuser_i);
            fail_count++;
          end
          if (m_axis_tdata_i[OFF_W-1:0] != want.offset) begin
            $error("payload_offset: expected %0d, got %0d",
                   want.offset, m_axis_tdata_i[OFF_W-1:0]);
            fail_count++;
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i)
        predicted_results.push_back(predict_heap_op(op_e'(s_axis_tuser_i),
                                                    s_axis_tdata_i[REQ_W-1:0],
                                                    s_axis_tdata_i[REQ_W+OFF_W-1:REQ_W]));
    end
    mismatches_o <= fail_count;
    pending_o    <= predicted_results.size();
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the first-fit heap allocator
// Directed corner words, then a random mix of allocs and frees of live
// blocks with corner words sprinkled in, under random backpressure on both
// sides; the checker beside the block does prediction and comparison.
// ----------------------------------------------------------------------------
module testbench;
  import ffha_pkg::*;

  logic                clk     = 1'b0;
  logic                rst_n   = 1'b0;
  logic                s_valid = 1'b0;
  logic                s_ready;
  logic [S_DATA_W-1:0] s_data  = '0;   // [15:0] request_bytes, [30:16] release_offset
  logic                s_user  = OP_ALLOC;   // [0] op
  logic                m_valid;
  logic                m_ready = 1'b0;
  logic [M_DATA_W-1:0] m_data;         // [14:0] payload_offset
  logic [1:0]          m_user;         // [1:0] status
  logic                quiet   = 1'b0; // no idling on either side once set

  int mismatches;
  int pending;
  int tx_idle_pct = 0;
  int n_alloc = 0, n_free = 0, n_corner = 0;
  int n_stat [4] = '{0, 0, 0, 0};

  // payload offsets handed out by the block: live ones, and every one seen
  logic [OFF_W-1:0] live_offsets [$];
  logic [OFF_W-1:0] seen_offsets [$];

  always #10 clk = ~clk;

  first_fit_heap_allocator uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user)
  );

  heap_alloc_checker result_check (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_i (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_i (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_i  (m_data),
    .m_axis_tuser_i  (m_user),
    .mismatches_o    (mismatches),
    .pending_o       (pending)
  );

  // Offer one word, hold it until taken, then maybe leave a gap.
  task automatic send_word(input op_e op, input logic [REQ_W-1:0] bytes,
                           input logic [OFF_W-1:0] off);
    s_valid <= 1'b1;
    s_user  <= op;
    s_data  <= S_DATA_W'({off, bytes});
    do @(posedge clk); while (!s_ready);
    if (!quiet && $urandom_range(0, 99) < tx_idle_pct) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  // Drop valid and wait for the checker to see every result back.
  task automatic drain;
    s_valid <= 1'b0;
    @(posedge clk);   // let the checker count the last accept in pending
    while (pending != 0) @(posedge clk);
  endtask

  // Pool upkeep at the falling edge: both sides only move at the rising
  // edge, so valid & ready here is the handshake of the coming edge.
  // A done result with a nonzero offset can only come from an alloc.
  always @(negedge clk) begin
    if (rst_n && m_valid && m_ready && status_e'(m_user) == STAT_DONE &&
        m_data[OFF_W-1:0] != '0) begin
      live_offsets.push_back(m_data[OFF_W-1:0]);
      seen_offsets.push_back(m_data[OFF_W-1:0]);
    end
  end

  // Result side: random ready bursts, one long hold-off early in the run
  // so the allocator fills its output and stalls the input.
  initial begin
    int stall_left;
    int rx_idle_pct;
    int cycle_no;
    int results_seen;
    logic long_done;
    stall_left   = 0;
    rx_idle_pct  = 0;
    cycle_no     = 0;
    results_seen = 0;
    long_done    = 1'b0;
    forever begin
      @(posedge clk);
      if (m_valid && m_ready) begin
        results_seen++;
        n_stat[m_user]++;
      end
      cycle_no++;
      if (cycle_no % 50 == 0) begin
        case ($urandom_range(0, 2))
          0: rx_idle_pct = 0;
          1: rx_idle_pct = 10;
          default: rx_idle_pct = 35;
        endcase
      end
      if (!rst_n) begin
        m_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_ready <= 1'b0;
      end else if (!long_done && results_seen >= 150) begin
        long_done  = 1'b1;
        stall_left = 299;
        m_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 99) < rx_idle_pct) begin
        stall_left = $urandom_range(0, 13);
        m_ready <= 1'b0;
      end else begin
        m_ready <= 1'b1;
      end
    end
  end

  // Stimulus
  initial begin
    int               r;
    int               idx;
    logic [REQ_W-1:0] bytes;
    logic [OFF_W-1:0] off;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part on a fresh heap; offsets follow from first fit.
    tx_idle_pct = 20;
    send_word(OP_ALLOC, 16'd0, '0);        // zero-size request
    send_word(OP_ALLOC, 16'hFFFF, '0);     // largest request, bigger than the heap
    send_word(OP_ALLOC, 16'd1, '0);        // smallest block (2 words) at 8, split
    send_word(OP_ALLOC, 16'd16, '0);       // 3 words at 24
    send_word(OP_FREE, '0, 15'd0);         // null
    send_word(OP_FREE, '0, 15'd7);         // null, top of the null range
    send_word(OP_FREE, '0, 15'd12);        // misaligned
    send_word(OP_FREE, '0, 15'h7FFF);      // misaligned, all ones
    send_word(OP_FREE, '0, 15'd24);        // real free
    send_word(OP_FREE, '0, 15'd24);        // double free
    send_word(OP_ALLOC, 16'd8, '0);        // 2 words into the 3-word hole: no split
    send_word(OP_FREE, '0, 15'd8);
    send_word(OP_ALLOC, 16'd9, '0);        // skips the 2-word hole, lands at 48
    send_word(OP_ALLOC, 16'd32768, '0);    // one word more than the heap
    send_word(OP_ALLOC, 16'd32000, '0);    // nearly all of the tail, at 72
    send_word(OP_ALLOC, 16'd4000, '0);     // tail remainder too small
    send_word(OP_FREE, '0, 15'd72);
    send_word(OP_ALLOC, 16'd16, '0);       // reuses the big hole, split again
    send_word(OP_FREE, '0, 15'd8);         // already free
    send_word(OP_ALLOC, 16'd8, '0);        // exact fit in the 2-word hole
    n_corner += 20;
    drain();
    live_offsets.delete();   // directed blocks stay put; random part starts clean

    for (int i = 0; i < 930; i++) begin
      if (i % 40 == 0) begin
        case ($urandom_range(0, 2))
          0: tx_idle_pct = 0;
          1: tx_idle_pct = 15;
          default: tx_idle_pct = 40;
        endcase
      end
      if (i == 830) quiet <= 1'b1;
      if (i == 450) drain();
      r     = $urandom_range(0, 99);
      bytes = REQ_W'($urandom);   // unused field carries noise
      off   = OFF_W'($urandom);
      if (r >= 50 && r < 82 && live_offsets.size() != 0) begin
        idx = $urandom_range(0, live_offsets.size() - 1);
        off = live_offsets[idx];
        live_offsets.delete(idx);
        n_free++;
        send_word(OP_FREE, bytes, off);
      end else if (r >= 82 && r < 86 && seen_offsets.size() != 0) begin
        // any block ever handed out: mostly a double free by now
        off = seen_offsets[$urandom_range(0, seen_offsets.size() - 1)];
        n_corner++;
        send_word(OP_FREE, bytes, off);
      end else if (r >= 86 && r < 89) begin
        n_corner++;
        send_word(OP_ALLOC, '0, off);
      end else if (r >= 89 && r < 93) begin
        n_corner++;
        send_word(OP_FREE, bytes, OFF_W'($urandom_range(0, 7)));
      end else if (r >= 93 && r < 97) begin
        off[2:0] = 3'($urandom_range(1, 7));
        n_corner++;
        send_word(OP_FREE, bytes, off);
      end else if (r >= 97) begin
        n_corner++;
        send_word(OP_ALLOC, REQ_W'($urandom_range(1, 65535)), off);
      end else begin
        // mostly small blocks, a few big ones to fill and fragment the heap
        case ($urandom_range(0, 19))
          0, 1:    bytes = REQ_W'($urandom_range(1025, 8192));
          2, 3, 4,
          5, 6:    bytes = REQ_W'($urandom_range(65, 1024));
          default: bytes = REQ_W'($urandom_range(1, 64));
        endcase
        n_alloc++;
        send_word(OP_ALLOC, bytes, off);
      end
    end

    drain();
    repeat (8) @(posedge clk);
    $display("Sent %0d allocs, %0d frees of live blocks, %0d corner words.",
             n_alloc, n_free, n_corner);
    $display("Results: %0d done, %0d zero-size, %0d no fit, %0d ignored frees.",
             n_stat[STAT_DONE], n_stat[STAT_ZERO], n_stat[STAT_NOFIT], n_stat[STAT_IGNORED]);
    if (mismatches == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog: far beyond a run where every walk crosses a fully split heap.
  initial begin
    #200ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
